[hdl/bpss_pkg.sv]
// ---------------------------------------------------------------------------
// bpss_pkg - shared types and constants for bright pixel strip steering
// Widths, gray weights, register indexes, turn codes and stream field
// positions used by the datapath, the decision logic and the checker.
// ---------------------------------------------------------------------------
package bpss_pkg;

	// Pixel and column widths
	localparam int PIX_BITS   = 8;
	localparam int COL_BITS   = 10;
	localparam int BOUND_BITS = 11;
	localparam int MAX_WIDTH  = 1024;

	// Strip totals
	localparam int COUNT_BITS = 21;

	// Gray conversion: (1868B + 9617G + 4899R + 8192) >> 14
	localparam int GRAY_SUM_BITS = 22;
	localparam int GRAY_SHIFT    = 14;
	localparam logic [GRAY_SUM_BITS-1:0] W_BLUE  = GRAY_SUM_BITS'(1868);
	localparam logic [GRAY_SUM_BITS-1:0] W_GREEN = GRAY_SUM_BITS'(9617);
	localparam logic [GRAY_SUM_BITS-1:0] W_RED   = GRAY_SUM_BITS'(4899);
	localparam logic [GRAY_SUM_BITS-1:0] GRAY_ROUND = GRAY_SUM_BITS'(8192);

	// Configuration port
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 21;
	localparam int THRESH_BITS   = 8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_LEFT_END       = 3'd0,
		REG_CENTER_END     = 3'd1,
		REG_RIGHT_START    = 3'd2,
		REG_RIGHT_END      = 3'd3,
		REG_GRAY_THRESHOLD = 3'd4,
		REG_NEAR_LIMIT     = 3'd5
	} cfg_reg_t;

	localparam logic [BOUND_BITS-1:0]  RST_LEFT_END       = BOUND_BITS'(340);
	localparam logic [BOUND_BITS-1:0]  RST_CENTER_END     = BOUND_BITS'(680);
	localparam logic [BOUND_BITS-1:0]  RST_RIGHT_START    = BOUND_BITS'(681);
	localparam logic [BOUND_BITS-1:0]  RST_RIGHT_END      = BOUND_BITS'(1021);
	localparam logic [THRESH_BITS-1:0] RST_GRAY_THRESHOLD = THRESH_BITS'(240);
	localparam logic [COUNT_BITS-1:0]  RST_NEAR_LIMIT     = COUNT_BITS'(6500);

	// Turn command codes
	typedef enum logic [1:0] {
		TURN_NONE = 2'd0,
		TURN_NEG  = 2'd1,
		TURN_POS  = 2'd2
	} turn_t;

	// Stream widths and output field positions
	localparam int S_TDATA_BITS  = 40;
	localparam int M_TDATA_BITS  = 72;
	localparam int OUT_FWD_POS   = 0;
	localparam int OUT_TURN_LO   = 1;
	localparam int OUT_LEFT_LO   = 3;
	localparam int OUT_CENTER_LO = OUT_LEFT_LO + COUNT_BITS;
	localparam int OUT_RIGHT_LO  = OUT_CENTER_LO + COUNT_BITS;
	localparam int OUT_USED_BITS = OUT_RIGHT_LO + COUNT_BITS;

	// Strip classification settings
	typedef struct packed {
		logic [BOUND_BITS-1:0]  left_end;
		logic [BOUND_BITS-1:0]  center_end;
		logic [BOUND_BITS-1:0]  right_start;
		logic [BOUND_BITS-1:0]  right_end;
		logic [THRESH_BITS-1:0] gray_threshold;
	} strip_cfg_t;

	// Per-pixel strip hits
	typedef struct packed {
		logic left_hit;
		logic center_hit;
		logic right_hit;
	} strip_hit_t;

endpackage

[hdl/bpss_pixel_class.sv]
// ---------------------------------------------------------------------------
// bpss_pixel_class - gray conversion and strip classification
// Converts one BGR pixel to gray, tests it against the threshold and
// reports which strips its column falls in.
// ---------------------------------------------------------------------------
module bpss_pixel_class
	import bpss_pkg::*;
(
	input  logic [PIX_BITS-1:0] blue,
	input  logic [PIX_BITS-1:0] green,
	input  logic [PIX_BITS-1:0] red,
	input  logic [COL_BITS-1:0] column,
	input  strip_cfg_t          cfg,
	output strip_hit_t          hit
);

	logic [GRAY_SUM_BITS-1:0] gray_sum;
	logic [PIX_BITS-1:0]      gray;
	logic [BOUND_BITS-1:0]    col_ext;
	logic                     in_image;
	logic                     bright;

	// Weighted sum with rounding, then drop the fraction
	assign gray_sum = GRAY_SUM_BITS'(blue) * W_BLUE
		+ GRAY_SUM_BITS'(green) * W_GREEN
		+ GRAY_SUM_BITS'(red) * W_RED
		+ GRAY_ROUND;
	assign gray = gray_sum[GRAY_SUM_BITS-1:GRAY_SHIFT];

	// Bright pixel inside the image
	assign in_image = 32'(column) < 32'(MAX_WIDTH);
	assign bright   = (gray > cfg.gray_threshold) && in_image;
	assign col_ext  = BOUND_BITS'(column);

	// Each strip tests its own bounds
	always_comb begin
		hit.left_hit   = bright && (col_ext < cfg.left_end);
		hit.center_hit = bright && (col_ext >= cfg.left_end) && (col_ext < cfg.center_end);
		hit.right_hit  = bright && (col_ext >= cfg.right_start) && (col_ext < cfg.right_end);
	end

endmodule

[hdl/bpss_steer.sv]
// ---------------------------------------------------------------------------
// bpss_steer - drive command from the frame totals
// Picks the strictly largest strip for the turn and compares the largest
// total with the near limit for forward motion; a tie gives a full stop.
// ---------------------------------------------------------------------------
module bpss_steer
	import bpss_pkg::*;
(
	input  logic [COUNT_BITS-1:0] left_count,
	input  logic [COUNT_BITS-1:0] center_count,
	input  logic [COUNT_BITS-1:0] right_count,
	input  logic [COUNT_BITS-1:0] near_limit,
	output logic                  move_forward,
	output turn_t                 turn
);

	logic [COUNT_BITS-1:0] top;
	logic                  near_ok;

	// Largest of the three totals
	always_comb begin
		top = left_count;
		if (center_count > top) begin
			top = center_count;
		end
		if (right_count > top) begin
			top = right_count;
		end
	end

	assign near_ok = top < near_limit;

	// Follow the strictly largest strip, stop on a tie
	always_comb begin
		if (left_count > right_count && left_count > center_count) begin
			turn         = TURN_NEG;
			move_forward = near_ok;
		end else if (center_count > left_count && center_count > right_count) begin
			turn         = TURN_NONE;
			move_forward = near_ok;
		end else if (right_count > left_count && right_count > center_count) begin
			turn         = TURN_POS;
			move_forward = near_ok;
		end else begin
			turn         = TURN_NONE;
			move_forward = 1'b0;
		end
	end

endmodule

[hdl/bright_pixel_strip_steering.sv]
// ---------------------------------------------------------------------------
// bright_pixel_strip_steering - bright pixel strip counter and steering
// Counts bright pixels in three column strips per frame and emits the
// totals with a drive command on the last pixel of each frame.
//
//   channel | signals                          | carries
//   --------+----------------------------------+---------------------------
//   s_*     | s_tvalid s_tready s_tdata s_tlast | one pixel per transaction
//   m_*     | m_tvalid m_tready m_tdata         | one result per frame
//   cfg_*   | cfg_we cfg_index cfg_data         | register writes, no wait
//
// One pixel per cycle sustained while s_tready is high. A last pixel passes
// the input register, the classification register and the result register,
// then the output register, which raises m_tvalid.
// Reset clears the counters, pipeline valids and loads register defaults.
// s_tready drops only while both the result register and the output
// register hold a frame result; it depends on registered state alone.
// ---------------------------------------------------------------------------
module bright_pixel_strip_steering
	import bpss_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// s_tdata: blue[7:0], green[15:8], red[23:16], column[33:24], zero fill
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [S_TDATA_BITS-1:0]  s_tdata,
	input  logic                     s_tlast,
	// m_tdata: move_forward[0], turn[2:1], left_count[23:3],
	//          center_count[44:24], right_count[65:45], zero fill
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [M_TDATA_BITS-1:0]  m_tdata,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	// Configuration registers
	strip_cfg_t            cfg_q;
	logic [COUNT_BITS-1:0] near_limit_q;

	// Pipeline
	logic                  advance;
	logic                  s1_valid, s1_last;
	logic [PIX_BITS-1:0]   blue_s1, green_s1, red_s1;
	logic [COL_BITS-1:0]   column_s1;
	strip_hit_t            hit_c;
	logic                  s2_valid, s2_last;
	strip_hit_t            hit_s2;
	logic [COUNT_BITS-1:0] left_q, center_q, right_q;
	logic [COUNT_BITS-1:0] left_nx, center_nx, right_nx;
	logic                  s3_valid;
	logic [COUNT_BITS-1:0] left_s3, center_s3, right_s3;
	logic                  m_load;
	logic                  fwd_c;
	turn_t                 turn_c;
	logic                  m_valid_q;
	logic [M_TDATA_BITS-1:0] m_data_q;

	// Stall only when both result slots are taken
	assign advance  = !(s3_valid && m_valid_q);
	assign s_tready = advance;
	assign m_load   = s3_valid && (!m_valid_q || m_tready);

	// Register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_end       <= RST_LEFT_END;
			cfg_q.center_end     <= RST_CENTER_END;
			cfg_q.right_start    <= RST_RIGHT_START;
			cfg_q.right_end      <= RST_RIGHT_END;
			cfg_q.gray_threshold <= RST_GRAY_THRESHOLD;
			near_limit_q         <= RST_NEAR_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEFT_END:       cfg_q.left_end       <= cfg_data[BOUND_BITS-1:0];
				REG_CENTER_END:     cfg_q.center_end     <= cfg_data[BOUND_BITS-1:0];
				REG_RIGHT_START:    cfg_q.right_start    <= cfg_data[BOUND_BITS-1:0];
				REG_RIGHT_END:      cfg_q.right_end      <= cfg_data[BOUND_BITS-1:0];
				REG_GRAY_THRESHOLD: cfg_q.gray_threshold <= cfg_data[THRESH_BITS-1:0];
				REG_NEAR_LIMIT:     near_limit_q         <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: capture the pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (advance) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			blue_s1   <= s_tdata[7:0];
			green_s1  <= s_tdata[15:8];
			red_s1    <= s_tdata[23:16];
			column_s1 <= s_tdata[33:24];
			s1_last   <= s_tlast;
		end
	end

	bpss_pixel_class u_class (
		.blue   (blue_s1),
		.green  (green_s1),
		.red    (red_s1),
		.column (column_s1),
		.cfg    (cfg_q),
		.hit    (hit_c)
	);

	// Stage 2: hold the strip hits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (advance) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid) begin
			hit_s2  <= hit_c;
			s2_last <= s1_last;
		end
	end

	// Saturating increments of the strip totals
	always_comb begin
		left_nx   = left_q;
		center_nx = center_q;
		right_nx  = right_q;
		if (hit_s2.left_hit && left_q != '1) begin
			left_nx = left_q + 1'b1;
		end
		if (hit_s2.center_hit && center_q != '1) begin
			center_nx = center_q + 1'b1;
		end
		if (hit_s2.right_hit && right_q != '1) begin
			right_nx = right_q + 1'b1;
		end
	end

	// Advance totals; clear them at frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			center_q <= '0;
			right_q  <= '0;
		end else if (advance && s2_valid) begin
			if (s2_last) begin
				left_q   <= '0;
				center_q <= '0;
				right_q  <= '0;
			end else begin
				left_q   <= left_nx;
				center_q <= center_nx;
				right_q  <= right_nx;
			end
		end
	end

	// Stage 3: frame totals awaiting the decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else if (advance && s2_valid && s2_last) begin
			s3_valid <= 1'b1;
		end else if (m_load) begin
			s3_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s2_valid && s2_last) begin
			left_s3   <= left_nx;
			center_s3 <= center_nx;
			right_s3  <= right_nx;
		end
	end

	bpss_steer u_steer (
		.left_count   (left_s3),
		.center_count (center_s3),
		.right_count  (right_s3),
		.near_limit   (near_limit_q),
		.move_forward (fwd_c),
		.turn         (turn_c)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (m_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (m_load) begin
			m_data_q <= {(M_TDATA_BITS - OUT_USED_BITS)'(0), right_s3, center_s3, left_s3,
				turn_c, fwd_c};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

[hdl/bpss_checker.sv]
// ---------------------------------------------------------------------------
// bpss_checker - port-level checks for bright pixel strip steering
// Watches the result stream for hold behaviour and for drive commands that
// disagree with the reported totals.
// ---------------------------------------------------------------------------
module bpss_checker
	import bpss_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [M_TDATA_BITS-1:0]  m_tdata
);

	logic [1:0]            turn_o;
	logic [COUNT_BITS-1:0] left_o, center_o, right_o;

	assign turn_o   = m_tdata[OUT_TURN_LO +: 2];
	assign left_o   = m_tdata[OUT_LEFT_LO +: COUNT_BITS];
	assign center_o = m_tdata[OUT_CENTER_LO +: COUNT_BITS];
	assign right_o  = m_tdata[OUT_RIGHT_LO +: COUNT_BITS];

	// Hold a stalled result transaction
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// A left turn needs a strictly largest left total
	a_turn_left: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && turn_o == TURN_NEG |-> left_o > center_o && left_o > right_o)
		else $error("left turn without a largest left strip");

	// A right turn needs a strictly largest right total
	a_turn_right: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && turn_o == TURN_POS |-> right_o > center_o && right_o > left_o)
		else $error("right turn without a largest right strip");

	// Forward motion never comes with a tie for the largest strip
	a_fwd_no_tie: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_FWD_POS] |->
			(left_o > center_o && left_o > right_o) ||
			(center_o > left_o && center_o > right_o) ||
			(right_o > left_o && right_o > center_o))
		else $error("forward motion on a tied frame");

endmodule

bind bright_pixel_strip_steering bpss_checker u_bpss_checker (.*);
